### rtl/pol_pkg.sv
// Shared codes, widths and the cell command type of the positional ordered list.
`default_nettype none

package pol_pkg;

  localparam int POL_CAPACITY = 32;

  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_RD_FWD    = 3'd6;
  localparam logic [OP_W-1:0] OP_RD_BWD    = 3'd7;

  localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_ELEMENT = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd4;

  typedef enum logic [2:0] {
    CMD_HOLD    = 3'd0,
    CMD_INS     = 3'd1,
    CMD_DEL     = 3'd2,
    CMD_ROT_FWD = 3'd3,
    CMD_ROT_BWD = 3'd4
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/positional_ordered_list_top.sv
// Top level of the positional ordered list: operation decode, read sequencer and cell chain.
//
// Input items arrive on the in_ channel and carry one operation each; results leave on
// the out_ channel. Inserts and deletes give a single status item in the cycle after
// they are taken, with out_tlast set. Every entry sits in its own cell and the cells
// that move shift together, so these operations run at one item per cycle while the
// receiver keeps up. A forward read rotates the occupied cells towards the front,
// emitting the front cell, one element item per cycle while the receiver takes them.
// A backward read rotates the whole ring of CAPACITY cells towards the back through
// one full turn, emitting the cell that wraps to the front, the elements coming out
// in the final count steps of the turn.
// In both cases the list is back in its original order when the final item, marked by
// out_tlast, has been sent, and the next input item is taken after that. A read of an
// empty list gives one list-empty item.
// Results go through an output register; the next item is taken while a result waits
// as long as the receiver takes it in the same cycle. When the receiver stalls, the
// block holds its result and accepts nothing further until it is taken.
// Reset clears the entry count and the sequencer; stored values need no reset.
`default_nettype none

module positional_ordered_list_top #(
  parameter int CAPACITY = pol_pkg::POL_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // position [7:0], value [39:8]
  input  wire logic [2:0]  in_tuser,   // op [2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // element [31:0]
  output logic [2:0]       out_tuser,  // status [2:0]
  output logic             out_tlast
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RD_FWD = 3'b010,
    S_RD_BWD = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [IDX_W-1:0]                step_r, step_nxt;
  logic                            out_valid_r;
  logic [pol_pkg::STATUS_W-1:0]    out_status_r;
  logic [pol_pkg::DATA_W-1:0]      out_elem_r;
  logic                            out_last_r;

  logic                            slot_free;
  logic                            in_acc;
  logic [pol_pkg::OP_W-1:0]        op;
  logic [pol_pkg::POS_W-1:0]       pos;
  logic signed [pol_pkg::DATA_W-1:0] value;

  logic [CMP_W-1:0]                pos_ext;
  logic [CMP_W-1:0]                cnt_ext;
  logic                            full;
  logic                            empty;
  logic                            ins_pos_ok;
  logic                            del_pos_ok;
  logic                            bwd_emitting;

  pol_pkg::cell_cmd_t              cmd;
  logic [IDX_W-1:0]                cmd_idx;
  logic signed [pol_pkg::DATA_W-1:0] bcast;
  logic                            emit;
  logic [pol_pkg::STATUS_W-1:0]    emit_status;
  logic [pol_pkg::DATA_W-1:0]      emit_elem;
  logic                            emit_last;

  logic signed [pol_pkg::DATA_W-1:0] cell_val [CAPACITY];

  assign op    = in_tuser[2:0];
  assign pos   = in_tdata[7:0];
  assign value = in_tdata[39:8];

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;

  assign pos_ext    = CMP_W'(pos);
  assign cnt_ext    = CMP_W'(count_r);
  assign full       = (count_r == CNT_W'(CAPACITY));
  assign empty      = (count_r == '0);
  assign ins_pos_ok = (pos_ext >= CMP_W'(2)) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign del_pos_ok = (pos_ext >= CMP_W'(2)) && (pos_ext <= cnt_ext);
  assign bwd_emitting = (CNT_W'(step_r) >= (CNT_W'(CAPACITY) - count_r));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    step_nxt    = step_r;
    cmd         = pol_pkg::CMD_HOLD;
    cmd_idx     = '0;
    bcast       = value;
    emit        = 1'b0;
    emit_status = pol_pkg::STAT_DONE;
    emit_elem   = '0;
    emit_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          emit = 1'b1;
          case (op)
            pol_pkg::OP_INS_FRONT, pol_pkg::OP_INS_BACK, pol_pkg::OP_INS_AT: begin
              if (full) begin
                emit_status = pol_pkg::STAT_FULL;
              end else if (op == pol_pkg::OP_INS_FRONT ||
                           (op == pol_pkg::OP_INS_AT && pos == 8'd1)) begin
                cmd       = pol_pkg::CMD_INS;
                cmd_idx   = '0;
                count_nxt = count_r + CNT_W'(1);
              end else if (op == pol_pkg::OP_INS_BACK) begin
                cmd       = pol_pkg::CMD_INS;
                cmd_idx   = IDX_W'(count_r);
                count_nxt = count_r + CNT_W'(1);
              end else if (ins_pos_ok) begin
                cmd       = pol_pkg::CMD_INS;
                cmd_idx   = IDX_W'(pos_ext - CMP_W'(1));
                count_nxt = count_r + CNT_W'(1);
              end else begin
                emit_status = pol_pkg::STAT_MISSING;
              end
            end
            pol_pkg::OP_DEL_BACK: begin
              if (empty) begin
                emit_status = pol_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            pol_pkg::OP_DEL_FRONT: begin
              if (empty) begin
                emit_status = pol_pkg::STAT_EMPTY;
              end else begin
                cmd       = pol_pkg::CMD_DEL;
                cmd_idx   = '0;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            pol_pkg::OP_DEL_AT: begin
              if (pos == 8'd1) begin
                if (empty) begin
                  emit_status = pol_pkg::STAT_EMPTY;
                end else begin
                  cmd       = pol_pkg::CMD_DEL;
                  cmd_idx   = '0;
                  count_nxt = count_r - CNT_W'(1);
                end
              end else if (del_pos_ok) begin
                cmd       = pol_pkg::CMD_DEL;
                cmd_idx   = IDX_W'(pos_ext - CMP_W'(1));
                count_nxt = count_r - CNT_W'(1);
              end else begin
                emit_status = pol_pkg::STAT_MISSING;
              end
            end
            pol_pkg::OP_RD_FWD, pol_pkg::OP_RD_BWD: begin
              if (empty) begin
                emit_status = pol_pkg::STAT_EMPTY;
              end else begin
                emit      = 1'b0;
                step_nxt  = '0;
                state_nxt = (op == pol_pkg::OP_RD_FWD) ? S_RD_FWD : S_RD_BWD;
              end
            end
            default: begin
              emit_status = pol_pkg::STAT_DONE;
            end
          endcase
        end
      end
      S_RD_FWD: begin
        bcast       = cell_val[0];
        emit_status = pol_pkg::STAT_ELEMENT;
        emit_elem   = cell_val[0];
        emit_last   = (step_r == IDX_W'(count_r - CNT_W'(1)));
        if (slot_free) begin
          emit    = 1'b1;
          cmd     = pol_pkg::CMD_ROT_FWD;
          cmd_idx = IDX_W'(count_r - CNT_W'(1));
          if (emit_last) begin
            state_nxt = S_IDLE;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + IDX_W'(1);
          end
        end
      end
      S_RD_BWD: begin
        emit_status = pol_pkg::STAT_ELEMENT;
        emit_elem   = cell_val[CAPACITY-1];
        emit_last   = (step_r == IDX_W'(CAPACITY - 1));
        if (slot_free || !bwd_emitting) begin
          emit = bwd_emitting;
          cmd  = pol_pkg::CMD_ROT_BWD;
          if (emit_last) begin
            state_nxt = S_IDLE;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [pol_pkg::DATA_W-1:0] left_val;
    logic signed [pol_pkg::DATA_W-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = cell_val[CAPACITY-1];
    end else begin : g_inner_l
      assign left_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[0];
    end else begin : g_inner_r
      assign right_val = cell_val[g+1];
    end

    pol_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (cmd_idx),
      .left_val  (left_val),
      .right_val (right_val),
      .bcast_val (bcast),
      .val       (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      if (slot_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      out_status_r <= emit_status;
      out_elem_r   <= emit_elem;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_elem_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (count_r != '0))
    else $error("Read sequencer active on an empty list.");

  a_read_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (count_r == $past(count_r)))
    else $error("Entry count changed during a read.");

  a_read_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op == pol_pkg::OP_RD_FWD || op == pol_pkg::OP_RD_BWD) && !empty)
      |=> (state_r != S_IDLE))
    else $error("Read of a non-empty list did not start the sequencer.");

  a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op != pol_pkg::OP_RD_FWD && op != pol_pkg::OP_RD_BWD)
      |=> (out_valid_r && out_last_r))
    else $error("Update item gave no final status item.");

endmodule

`default_nettype wire

### rtl/pol_cell.sv
// One storage cell of the list chain, holding the entry at a fixed list index.
`default_nettype none

module pol_cell #(
  parameter int CAPACITY = pol_pkg::POL_CAPACITY,
  parameter int INDEX    = 0
) (
  input  wire logic                             clk,
  input  wire pol_pkg::cell_cmd_t               cmd,
  input  wire logic [$clog2(CAPACITY)-1:0]      idx,
  input  wire logic signed [pol_pkg::DATA_W-1:0] left_val,
  input  wire logic signed [pol_pkg::DATA_W-1:0] right_val,
  input  wire logic signed [pol_pkg::DATA_W-1:0] bcast_val,
  output logic signed [pol_pkg::DATA_W-1:0]     val
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [pol_pkg::DATA_W-1:0] val_r;
  logic signed [pol_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (cmd)
      pol_pkg::CMD_INS: begin
        if (MY_IDX > idx) begin
          val_nxt = left_val;
        end else if (MY_IDX == idx) begin
          val_nxt = bcast_val;
        end
      end
      pol_pkg::CMD_DEL: begin
        if (MY_IDX >= idx) begin
          val_nxt = right_val;
        end
      end
      pol_pkg::CMD_ROT_FWD: begin
        if (MY_IDX == idx) begin
          val_nxt = bcast_val;
        end else if (MY_IDX < idx) begin
          val_nxt = right_val;
        end
      end
      pol_pkg::CMD_ROT_BWD: begin
        val_nxt = left_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire
